/* sv/fdsu_pkg.sv */
// ----------------------------------------------------------------------------
// fdsu_pkg: shared types and constants of the field splitter
// Item, result and configuration types, register indexes and reset values.
// ----------------------------------------------------------------------------
package fdsu_pkg;

   // Longest delimiter in bytes, and the most bytes held between input beats.
   localparam int DELIM_MAX = 8;
   localparam int HELD_MAX  = DELIM_MAX - 1;

   // Width of a byte count that can hold DELIM_MAX itself.
   localparam int CNT_W = $clog2(DELIM_MAX + 1);
   // Width of an index into the scan window.
   localparam int IDX_W = $clog2(DELIM_MAX);

   // Configuration register indexes.
   localparam logic CSR_DELIM_LEN   = 1'b0;
   localparam logic CSR_DELIM_BYTES = 1'b1;

   // Register reset values: a four byte delimiter "#//#".
   localparam logic [3:0]  DELIM_LEN_RESET   = 4'd4;
   localparam logic [63:0] DELIM_BYTES_RESET = 64'h0000_0000_232F_2F23;

   // Result kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // One input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       record_end;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic       kind;
      logic [7:0] field_byte;
      logic       closes_record;
      logic       last_of_run;
   } result_type;

   // Configuration as seen by the scanner; the length is already clamped.
   typedef struct packed {
      logic [CNT_W-1:0]          eff_len;
      logic [8*DELIM_MAX-1:0]    delim_bytes;
   } cfg_type;

endpackage

/* sv/fdsu_front.sv */
// ----------------------------------------------------------------------------
// fdsu_front: input queue of the field splitter
// Accepts input beats into a two entry queue that feeds the scanner.
// ----------------------------------------------------------------------------
module fdsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  fdsu_pkg::item_type push_item,
   output logic               head_valid,
   output fdsu_pkg::item_type head_item,
   input  logic               head_take
);

   fdsu_pkg::item_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_take;

   // Queue status and head entry.
   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = head_take && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_take;
      count_in  = count_ff + 2'(do_push) - 2'(do_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/fdsu_back.sv */
// ----------------------------------------------------------------------------
// fdsu_back: delimiter scanner of the field splitter
// Scans the held bytes plus the new byte, one result beat per cycle unless
// the output stalls; keeps the unmatched prefix tail for the next input beat.
// ----------------------------------------------------------------------------
module fdsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fdsu_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  fdsu_pkg::item_type   head_item,
   output logic                 head_take,
   output logic                 out_valid,
   output fdsu_pkg::result_type out_result,
   input  logic                 out_pop
);

   localparam int DM = fdsu_pkg::DELIM_MAX;
   localparam int CW = fdsu_pkg::CNT_W;
   localparam int IW = fdsu_pkg::IDX_W;

   // Scan window: position 0 is the current scan position.
   logic [7:0]           win_ff [DM];
   logic [7:0]           win_in [DM];
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 active_ff, active_in;
   logic                 last_ff, last_in;

   // One result waits in the pending slot until it is known whether it is
   // the last one of its input beat.
   logic                 pend_valid_ff, pend_valid_in;
   fdsu_pkg::result_type pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   fdsu_pkg::result_type out_ff, out_in;

   logic                 out_free, step_ok;
   logic [CW-1:0]        match_len;
   logic                 match_ok;
   logic                 produce, finish, load;
   fdsu_pkg::result_type new_result;
   logic [CW-1:0]        shift_amt;
   logic [7:0]           win_sh [DM];
   logic [CW-1:0]        sh_idx;

   assign out_free = !out_valid_ff || out_pop;
   assign step_ok  = active_ff && (!pend_valid_ff || out_free);

   // Compare the window against the delimiter over min(count, length) bytes.
   always_comb begin
      match_len = (cnt_ff < cfg.eff_len) ? cnt_ff : cfg.eff_len;
      match_ok  = 1'b1;
      for (int k = 0; k < DM; k++) begin
         if ((CW'(k) < match_len) && (win_ff[k] != cfg.delim_bytes[8*k +: 8])) begin
            match_ok = 1'b0;
         end
      end
   end

   // Decide what one scan step does.
   always_comb begin
      produce    = 1'b0;
      finish     = 1'b0;
      shift_amt  = '0;
      last_in    = last_ff;
      new_result = '{kind: fdsu_pkg::KIND_DATA, field_byte: win_ff[0],
                     closes_record: 1'b0, last_of_run: 1'b0};
      priority if (cnt_ff == '0) begin
         if (last_ff) begin
            // Record ends here: close the final field.
            produce    = 1'b1;
            last_in    = 1'b0;
            new_result = '{kind: fdsu_pkg::KIND_END, field_byte: 8'd0,
                           closes_record: 1'b1, last_of_run: 1'b0};
         end else begin
            finish = 1'b1;
         end
      end else if (match_ok && (match_len == cfg.eff_len)) begin
         // Full delimiter match ends a field.
         produce    = 1'b1;
         shift_amt  = cfg.eff_len;
         new_result = '{kind: fdsu_pkg::KIND_END, field_byte: 8'd0,
                        closes_record: 1'b0, last_of_run: 1'b0};
      end else if (match_ok && !last_ff) begin
         // Proper prefix: keep holding the rest.
         finish = 1'b1;
      end else begin
         // Mismatch, or flushing at the end of the record.
         produce   = 1'b1;
         shift_amt = CW'(1);
      end
      if (!step_ok) begin
         produce = 1'b0;
         finish  = 1'b0;
         last_in = last_ff;
      end
   end

   // Window shifted by the consumed byte count.
   always_comb begin
      for (int k = 0; k < DM; k++) begin
         sh_idx    = CW'(k) + shift_amt;
         win_sh[k] = (sh_idx < CW'(DM)) ? win_ff[sh_idx[IW-1:0]] : win_ff[k];
      end
   end

   // A new beat is loaded when idle or in the cycle that finishes the last one.
   assign load      = head_valid && (!active_ff || finish);
   assign head_take = load;

   // Window, count and result slots.
   always_comb begin
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !out_pop;
      out_in        = out_ff;

      if (produce) begin
         win_in = win_sh;
         cnt_in = cnt_ff - shift_amt;
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = new_result;
      end

      if (finish) begin
         active_in = 1'b0;
         if (pend_valid_ff) begin
            out_valid_in       = 1'b1;
            out_in             = pend_ff;
            out_in.last_of_run = 1'b1;
         end
         pend_valid_in = 1'b0;
      end

      if (load) begin
         win_in[cnt_ff[IW-1:0]] = head_item.data_byte;
         cnt_in                 = cnt_ff + CW'(1);
         active_in              = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         active_ff     <= 1'b0;
         last_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         active_ff     <= active_in;
         last_ff       <= load ? head_item.record_end : last_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

/* sv/multibyte_delimiter_field_splitter_unit.sv */
// ----------------------------------------------------------------------------
// multibyte_delimiter_field_splitter_unit: record field splitter
// Splits a byte stream of records into fields at a programmable delimiter.
// ----------------------------------------------------------------------------
// Bytes enter through a two entry input queue; a scanner then works on the
// held delimiter prefix plus the new byte and produces one result beat per
// cycle into an output register, unless the output is stalled. An input
// byte is first loaded, then yields one result per scan step, and a byte
// whose results end the scan in a held prefix or an empty window takes one
// more step to finish, which overlaps the load of the next byte. A new byte
// is loaded only once the scan of the last one finishes. The last result of
// each input byte is known only when the scan of that byte ends, so it
// appears with last_of_run set then. Configuration writes take effect at
// once; the user makes them only while no byte is in flight, and the block
// itself does not enforce this. Bytes still held from the current record are
// then rescanned against the new delimiter together with the next byte.
// ----------------------------------------------------------------------------
module multibyte_delimiter_field_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_record_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_field_byte,
   output logic        rsp_closes_record,
   output logic        rsp_last_of_run,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   localparam int CW = fdsu_pkg::CNT_W;

   logic [3:0]           delim_len_ff, delim_len_in;
   logic [63:0]          delim_bytes_ff, delim_bytes_in;
   fdsu_pkg::cfg_type    cfg;
   fdsu_pkg::item_type   push_item, head_item;
   logic                 head_valid, head_take;
   logic                 out_valid;
   fdsu_pkg::result_type out_result;

   // Configuration registers.
   always_comb begin
      delim_len_in   = delim_len_ff;
      delim_bytes_in = delim_bytes_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            fdsu_pkg::CSR_DELIM_LEN:   delim_len_in   = csr_data[3:0];
            fdsu_pkg::CSR_DELIM_BYTES: delim_bytes_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_len_ff   <= fdsu_pkg::DELIM_LEN_RESET;
         delim_bytes_ff <= fdsu_pkg::DELIM_BYTES_RESET;
      end else begin
         delim_len_ff   <= delim_len_in;
         delim_bytes_ff <= delim_bytes_in;
      end
   end

   // Clamp the length: zero acts as one, anything longer saturates.
   always_comb begin
      if (delim_len_ff == 4'd0) begin
         cfg.eff_len = CW'(1);
      end else if ({1'b0, delim_len_ff} > 5'(fdsu_pkg::DELIM_MAX)) begin
         cfg.eff_len = CW'(fdsu_pkg::DELIM_MAX);
      end else begin
         cfg.eff_len = CW'(delim_len_ff);
      end
      cfg.delim_bytes = delim_bytes_ff;
   end

   assign push_item = '{data_byte: req_data_byte, record_end: req_record_end};

   fdsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .push_item  (push_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take)
   );

   fdsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take),
      .out_valid  (out_valid),
      .out_result (out_result),
      .out_pop    (rsp_pop)
   );

   // Result beat on the output ports.
   assign rsp_empty         = !out_valid;
   assign rsp_kind          = out_result.kind;
   assign rsp_field_byte    = out_result.field_byte;
   assign rsp_closes_record = out_result.closes_record;
   assign rsp_last_of_run   = out_result.last_of_run;

endmodule
